/* sv/ngh_pkg.sv */
// Shared types, constants and microcode table for the hysteresis noise gate.
// Used by ngh_cfg, ngh_seq, ngh_dp, the top level and the checker.
package ngh_pkg;

	// Field widths
	localparam int SAMPLE_BITS = 24;
	localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int COEF_W      = 16;
	localparam int THR_W       = 23;
	localparam int GAIN_W      = 17;
	localparam int FRAC_BITS   = 16;
	localparam int ENV_W       = SAMPLE_BITS;

	// Shared multiplier: signed A by signed B operands
	localparam int MA_W  = (SAMPLE_BITS + 1 > THR_W + 1) ? SAMPLE_BITS + 1 : THR_W + 1;
	localparam int MB_W  = GAIN_W + 1;
	localparam int P_W   = MA_W + MB_W;
	localparam int LVL_W = THR_W + 1;
	localparam int CMP_W = ((ENV_W > LVL_W) ? ENV_W : LVL_W) + 1;

	// Gain ramp constants
	localparam logic [GAIN_W-1:0] UNITY_GAIN  = 17'h10000;
	localparam logic [COEF_W-1:0] SMOOTH_COEF = 16'd655;

	// Register reset values
	localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd6554;
	localparam logic [COEF_W-1:0] RELEASE_RST = 16'd66;
	localparam logic [THR_W-1:0]  THR_RST     = 23'd10486;
	localparam logic [COEF_W-1:0] HYST_RST    = 16'd655;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_ATTACK,
		REG_RELEASE,
		REG_THRESHOLD,
		REG_HYST
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] attack_coef;
		logic [COEF_W-1:0] release_coef;
		logic [THR_W-1:0]  gate_threshold;
		logic [COEF_W-1:0] hyst_frac;
	} cfg_t;

	// Microcode
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_WAIT     = 3'd0;
	localparam step_t ST_MUL_HYST = 3'd1;
	localparam step_t ST_MUL_ENV  = 3'd2;
	localparam step_t ST_ENV_GATE = 3'd3;
	localparam step_t ST_MUL_GAIN = 3'd4;
	localparam step_t ST_GAIN     = 3'd5;
	localparam step_t ST_MUL_OUT  = 3'd6;
	localparam step_t ST_OUT      = 3'd7;

	// Condition a step waits on before it advances
	typedef enum logic [1:0] {
		WT_NONE,
		WT_IN,
		WT_OUT
	} wait_t;

	// Multiplier operand pair
	typedef enum logic [1:0] {
		MOP_HYST,
		MOP_ENV,
		MOP_GAIN,
		MOP_OUT
	} mop_t;

	typedef struct packed {
		wait_t wt;
		logic  mul_en;
		mop_t  mop;
		logic  ld_x;
		logic  ld_lvl;
		logic  ld_env;
		logic  ld_gain;
		logic  ld_out;
		step_t nxt;
	} uword_t;

	// Status from datapath to sequencer
	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

	localparam uword_t UW_NOP = '{
		wt: WT_NONE, mul_en: 1'b0, mop: MOP_HYST, ld_x: 1'b0, ld_lvl: 1'b0,
		ld_env: 1'b0, ld_gain: 1'b0, ld_out: 1'b0, nxt: ST_WAIT
	};

	// Control store: one word per step
	function automatic uword_t ucode_rom(input step_t addr);
		uword_t w;
		w = UW_NOP;
		case (addr)
			ST_WAIT: begin
				w.wt   = WT_IN;
				w.ld_x = 1'b1;
				w.nxt  = ST_MUL_HYST;
			end
			ST_MUL_HYST: begin
				w.mul_en = 1'b1;
				w.mop    = MOP_HYST;
				w.nxt    = ST_MUL_ENV;
			end
			ST_MUL_ENV: begin
				w.ld_lvl = 1'b1;
				w.mul_en = 1'b1;
				w.mop    = MOP_ENV;
				w.nxt    = ST_ENV_GATE;
			end
			ST_ENV_GATE: begin
				w.ld_env = 1'b1;
				w.nxt    = ST_MUL_GAIN;
			end
			ST_MUL_GAIN: begin
				w.mul_en = 1'b1;
				w.mop    = MOP_GAIN;
				w.nxt    = ST_GAIN;
			end
			ST_GAIN: begin
				w.ld_gain = 1'b1;
				w.nxt     = ST_MUL_OUT;
			end
			ST_MUL_OUT: begin
				w.mul_en = 1'b1;
				w.mop    = MOP_OUT;
				w.nxt    = ST_OUT;
			end
			ST_OUT: begin
				w.wt     = WT_OUT;
				w.ld_out = 1'b1;
				w.nxt    = ST_WAIT;
			end
			default: begin
				w = UW_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

/* sv/noise_gate_hysteresis.sv */
// Top level of the hysteresis noise gate: APB registers, sequencer, datapath.
// Depends on ngh_pkg, ngh_cfg, ngh_seq and ngh_dp.
//
//  channel   direction  signals                        contents
//  s_axis    in         s_tvalid s_tready s_tdata      sample_in
//  m_axis    out        m_tvalid m_tready m_tdata      sample_out, gate_open in m_tuser
//  apb       in/out     psel penable pwrite paddr ...  four registers at 4*index
//
// Each sample runs through a wait step, then seven microcode steps around the
// single shared 25x18 multiplier (four products, each followed by its update).
// s_tready is high only in the wait step; the next sample is taken once the last one
// has reached the output register, which holds it until the transfer completes.
// The final step stalls while the output register is full and m_tready is low.
// Reset clears the envelope, closes the gate, sets unity gain and loads register defaults.
module noise_gate_hysteresis
	import ngh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [DATA_W-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample_in
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DATA_W-1:0]  m_tdata,   // [SAMPLE_BITS-1:0] sample_out
	output logic [0:0]         m_tuser,   // [0] gate_open
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t                          cfg;
	uword_t                        ctrl;
	dp_stat_t                      stat;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          gate_open;

	ngh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ngh_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.in_ready (s_tready),
		.ctrl     (ctrl)
	);

	ngh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctrl       (ctrl),
		.sample_in  (signed'(s_tdata[SAMPLE_BITS-1:0])),
		.out_ready  (m_tready),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.sample_out (sample_out),
		.gate_open  (gate_open)
	);

	// Pad the result to whole bytes
	assign m_tdata = DATA_W'(unsigned'(sample_out));
	assign m_tuser = gate_open;

endmodule

/* sv/ngh_cfg.sv */
// Configuration register file behind an APB-style port.
// Depends on ngh_pkg for register indexes, widths and reset values.
module ngh_cfg
	import ngh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Take a write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_coef    <= ATTACK_RST;
			cfg_q.release_coef   <= RELEASE_RST;
			cfg_q.gate_threshold <= THR_RST;
			cfg_q.hyst_frac      <= HYST_RST;
		end else if (wr) begin
			case (idx)
				REG_ATTACK:    cfg_q.attack_coef    <= pwdata[COEF_W-1:0];
				REG_RELEASE:   cfg_q.release_coef   <= pwdata[COEF_W-1:0];
				REG_THRESHOLD: cfg_q.gate_threshold <= pwdata[THR_W-1:0];
				REG_HYST:      cfg_q.hyst_frac      <= pwdata[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			REG_ATTACK:    prdata = PDATA_W'(cfg_q.attack_coef);
			REG_RELEASE:   prdata = PDATA_W'(cfg_q.release_coef);
			REG_THRESHOLD: prdata = PDATA_W'(cfg_q.gate_threshold);
			REG_HYST:      prdata = PDATA_W'(cfg_q.hyst_frac);
			default:       prdata = '0;
		endcase
	end

endmodule

/* sv/ngh_seq.sv */
// Microcode sequencer: step counter, control store lookup and wait conditions.
// Depends on ngh_pkg for the control word, step codes and ucode_rom.
module ngh_seq
	import ngh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output logic     in_ready,
	output uword_t   ctrl
);

	step_t  step_q;
	uword_t word;
	logic   go;

	assign word     = ucode_rom(step_q);
	assign in_ready = (word.wt == WT_IN);

	// Decide whether the current step may complete
	always_comb begin
		case (word.wt)
			WT_NONE: go = 1'b1;
			WT_IN:   go = in_valid;
			WT_OUT:  go = ~stat.out_busy;
			default: go = 1'b0;
		endcase
	end

	// Gate the load strobes with the step's condition
	always_comb begin
		ctrl         = word;
		ctrl.mul_en  = word.mul_en & go;
		ctrl.ld_x    = word.ld_x & go;
		ctrl.ld_lvl  = word.ld_lvl & go;
		ctrl.ld_env  = word.ld_env & go;
		ctrl.ld_gain = word.ld_gain & go;
		ctrl.ld_out  = word.ld_out & go;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else if (go) begin
			step_q <= word.nxt;
		end
	end

endmodule

/* sv/ngh_dp.sv */
// Datapath: shared multiplier, envelope, gate, gain ramp and output register.
// Depends on ngh_pkg; driven by the control word from ngh_seq.
module ngh_dp
	import ngh_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  uword_t                        ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          out_ready,
	output dp_stat_t                      stat,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          gate_open
);

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [P_W-1:0]         p_q;
	logic [LVL_W-1:0]              open_lvl_q;
	logic [LVL_W-1:0]              close_lvl_q;
	logic [ENV_W-1:0]              env_q;
	logic                          gate_q;
	logic [GAIN_W-1:0]             gain_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_gate_q;
	logic                          out_valid_q;

	logic signed [MA_W-1:0]  x_ext;
	logic signed [MA_W-1:0]  mag;
	logic signed [MA_W-1:0]  diff;
	logic [COEF_W-1:0]       coef;
	logic [GAIN_W-1:0]       target;
	logic signed [MA_W-1:0]  gdiff;
	logic signed [MA_W-1:0]  op_a;
	logic signed [MB_W-1:0]  op_b;
	logic signed [P_W-1:0]   prod;
	logic signed [P_W-1:0]   p_sh;
	logic [THR_W-1:0]        delta;
	logic signed [P_W-1:0]   env_sum;
	logic [ENV_W-1:0]        env_new;
	logic [CMP_W-1:0]        env_c;
	logic                    gate_new;
	logic signed [P_W-1:0]   gain_sum;

	// Envelope error and gain error
	always_comb begin
		x_ext  = MA_W'(x_q);
		mag    = x_ext[MA_W-1] ? -x_ext : x_ext;
		diff   = mag - signed'(MA_W'(env_q));
		coef   = (diff > 0) ? cfg.attack_coef : cfg.release_coef;
		target = gate_q ? UNITY_GAIN : '0;
		gdiff  = signed'(MA_W'(target)) - signed'(MA_W'(gain_q));
	end

	// Select multiplier operands for the step
	always_comb begin
		case (ctrl.mop)
			MOP_HYST: begin
				op_a = signed'(MA_W'(cfg.gate_threshold));
				op_b = signed'(MB_W'(cfg.hyst_frac));
			end
			MOP_ENV: begin
				op_a = diff;
				op_b = signed'(MB_W'(coef));
			end
			MOP_GAIN: begin
				op_a = gdiff;
				op_b = signed'(MB_W'(SMOOTH_COEF));
			end
			MOP_OUT: begin
				op_a = x_ext;
				op_b = signed'(MB_W'(gain_q));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// Truncate the registered product toward minus infinity
	always_comb begin
		p_sh     = p_q >>> FRAC_BITS;
		delta    = p_sh[THR_W-1:0];
		env_sum  = signed'(P_W'(env_q)) + p_sh;
		env_new  = env_sum[ENV_W-1:0];
		env_c    = CMP_W'(env_new);
		gain_sum = signed'(P_W'(gain_q)) + p_sh;
		if (!gate_q) begin
			gate_new = env_c > CMP_W'(open_lvl_q);
		end else begin
			gate_new = !(env_c < CMP_W'(close_lvl_q));
		end
	end

	// Hold sample, product, switching levels and the output data and gate flag
	always_ff @(posedge clk) begin
		if (ctrl.ld_x) begin
			x_q <= sample_in;
		end
		if (ctrl.mul_en) begin
			p_q <= prod;
		end
		if (ctrl.ld_lvl) begin
			open_lvl_q  <= LVL_W'(cfg.gate_threshold) + LVL_W'(delta);
			close_lvl_q <= LVL_W'(cfg.gate_threshold) - LVL_W'(delta);
		end
		if (ctrl.ld_out) begin
			out_data_q <= p_sh[SAMPLE_BITS-1:0];
			out_gate_q <= gate_q;
		end
	end

	// Update envelope, gate and gain state; hold the result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q       <= '0;
			gate_q      <= 1'b0;
			gain_q      <= UNITY_GAIN;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.ld_env) begin
				env_q  <= env_new;
				gate_q <= gate_new;
			end
			if (ctrl.ld_gain) begin
				gain_q <= gain_sum[GAIN_W-1:0];
			end
			if (ctrl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q & ~out_ready;
	assign out_valid     = out_valid_q;
	assign sample_out    = out_data_q;
	assign gate_open     = out_gate_q;

endmodule

/* sv/ngh_checker.sv */
// Port-level checks for the hysteresis noise gate, attached by bind.
// Depends on ngh_pkg for port widths and register indexes.
module ngh_checker
	import ngh_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [DATA_W-1:0]  m_tdata,
	input logic [0:0]         m_tuser,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata,
	input logic               pready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// One sample at a time: no transfer in the cycle after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in consecutive cycles");

	// Threshold write reads back
	a_thr_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[3:2] == REG_THRESHOLD)
		|=> (paddr[3:2] != REG_THRESHOLD)
			|| (prdata == {9'd0, $past(pwdata[THR_W-1:0])}))
		else $error("threshold register did not take write");

endmodule

bind noise_gate_hysteresis ngh_checker u_ngh_checker (.*);
